>>> sv/tcsw_pkg.sv
package tcsw_pkg;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] REG_MARGIN_LEFT   = 2'd0;
  localparam logic [1:0] REG_MARGIN_RIGHT  = 2'd1;
  localparam logic [1:0] REG_MARGIN_TOP    = 2'd2;
  localparam logic [1:0] REG_MARGIN_BOTTOM = 2'd3;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic [6:0] LEFT_RST   = 7'd0;
  localparam logic [6:0] RIGHT_RST  = 7'd80;
  localparam logic [4:0] TOP_RST    = 5'd0;
  localparam logic [4:0] BOTTOM_RST = 5'd25;

  typedef struct packed {
    logic [6:0] left;
    logic [6:0] right;
    logic [4:0] top;
    logic [4:0] bottom;
  } margins_t;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic       store;
    logic       drop;
    logic       scroll;
    logic [6:0] wr_col;
    logic [4:0] wr_row;
  } put_result_t;

  function automatic logic cell_in_buf(input logic [7:0] x, input logic [5:0] y,
                                       input int cols, input int rows);
    return (32'(x) < cols) && (32'(y) < rows);
  endfunction

endpackage

>>> sv/tcsw_put_step.sv
module tcsw_put_step import tcsw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic [6:0]  cur_col,
  input  logic [4:0]  cur_row,
  input  margins_t    margins,
  input  logic [7:0]  char_code,
  input  logic        move_x,
  input  logic [6:0]  new_x,
  input  logic        move_y,
  input  logic [4:0]  new_y,
  output put_result_t res
);

  logic [6:0] cx;
  logic [4:0] cy;
  logic [6:0] cx_inc;
  logic [4:0] nl_row;
  logic       nl_scroll;
  logic       is_nl;
  logic       wrap;

  assign cx     = move_x ? new_x : cur_col;
  assign cy     = move_y ? new_y : cur_row;
  assign cx_inc = cx + 7'd1;
  assign is_nl  = (char_code == CH_NEWLINE);
  assign wrap   = !is_nl && (cx_inc == margins.right);

  // newline from row cy; a scroll steps back to cy itself
  assign nl_row    = cy + 5'd1;
  assign nl_scroll = (margins.bottom != 5'd0) && (nl_row == margins.bottom - 5'd1);

  always_comb begin
    res        = '0;
    res.wr_col = cx;
    res.wr_row = cy;
    if (!is_nl) begin
      res.store = cell_in_buf({1'b0, cx}, {1'b0, cy}, COLS, ROWS);
      res.drop  = !res.store;
    end
    if (is_nl || wrap) begin
      res.col    = margins.left;
      res.row    = nl_scroll ? cy : nl_row;
      res.scroll = nl_scroll;
    end else begin
      res.col = cx_inc;
      res.row = cy;
    end
  end

endmodule

>>> sv/text_cursor_scroll_writer.sv
// Character-cell text buffer, ROWS x COLS bytes, with cursor and margin box.
// Input channel (in_valid/in_stall): one transaction per item, func selects
// put, clear+home, read cell or no-op. Output channel (out_valid/out_stall):
// exactly one result transaction per item: cursor after the item, read data,
// scroll and dropped-write flags. Output is registered; a stalled result holds.
// Write margins through cfg_we/cfg_index/cfg_data only while idle (unenforced).
// Cells live in one single-port-write, one-read synchronous RAM (registered read).
// Every write is staged through a pending-write register, one cell per cycle.
// Put without scroll, read, no-op: IDLE accepts, then RESP registers the result.
// A scroll goes through SCR_WAIT, COPY (each box row takes the one below it)
// and FILL (spaces into the bottom box row), one RAM cell per cycle, then RESP.
// COPY is skipped when top+1 >= bottom, COPY and FILL when left >= right.
// Clear walks the whole RAM in CLEAR, then goes to RESP.
// One item is in flight at a time; in_stall is high whenever not idle, and an
// item finishing while the previous result is stalled waits for it.
// Reset: margins go to 0/80/0/25, cursor to 0,0, and a clearing pass over all
// COLS*ROWS cells zeroes the RAM with in_stall held high.
module text_cursor_scroll_writer import tcsw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] char_code,
  input  logic       move_x,
  input  logic [6:0] new_x,
  input  logic       move_y,
  input  logic [4:0] new_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic [7:0] read_char,
  output logic       scrolled,
  output logic       write_dropped,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int NCELLS = COLS * ROWS;
  localparam int AW     = $clog2(NCELLS);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CLEAR    = 3'd1;
  localparam logic [2:0] ST_SCR_WAIT = 3'd2;
  localparam logic [2:0] ST_COPY     = 3'd3;
  localparam logic [2:0] ST_FILL     = 3'd4;
  localparam logic [2:0] ST_RESP     = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] x, input logic [5:0] y);
    return AW'(32'(y) * COLS + 32'(x));
  endfunction

  logic [2:0]    state;
  margins_t      margins;
  logic [6:0]    cur_col;
  logic [4:0]    cur_row;
  logic [AW-1:0] clr_cnt;
  logic          quiet;
  logic [6:0]    sx;
  logic [4:0]    sy;
  logic          res_scroll;
  logic          res_drop;
  logic          res_read;

  // pending write: lands in the cycle after it is set up
  logic          pw_en;
  logic [AW-1:0] pw_addr;
  logic          pw_copy;
  logic [7:0]    pw_data;

  logic [7:0]    cells [NCELLS];
  logic [7:0]    rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  put_result_t   put;
  logic          accept;
  logic [6:0]    sx_inc;
  logic [4:0]    fill_row;
  logic          src_ok;

  tcsw_put_step #(.COLS(COLS), .ROWS(ROWS)) u_put_step (
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .margins   (margins),
    .char_code (char_code),
    .move_x    (move_x),
    .new_x     (new_x),
    .move_y    (move_y),
    .new_y     (new_y),
    .res       (put)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign sx_inc   = sx + 7'd1;
  assign fill_row = margins.bottom - 5'd1;
  assign src_ok   = cell_in_buf({1'b0, sx}, {1'b0, sy} + 6'd1, COLS, ROWS);

  always_comb begin
    if (state == ST_COPY) begin
      rd_en   = src_ok;
      rd_addr = cell_addr({1'b0, sx}, {1'b0, sy} + 6'd1);
    end else begin
      rd_en   = accept && (func == FUNC_READ) &&
                cell_in_buf({1'b0, new_x}, {1'b0, new_y}, COLS, ROWS);
      rd_addr = cell_addr({1'b0, new_x}, {1'b0, new_y});
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= cells[rd_addr];
    end
    if (pw_en) begin
      cells[pw_addr] <= pw_copy ? rdata : pw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      margins   <= '{left: LEFT_RST, right: RIGHT_RST, top: TOP_RST, bottom: BOTTOM_RST};
      cur_col   <= '0;
      cur_row   <= '0;
      clr_cnt   <= '0;
      quiet     <= 1'b1;
      out_valid <= 1'b0;
      pw_en     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MARGIN_LEFT:   margins.left   <= cfg_data;
          REG_MARGIN_RIGHT:  margins.right  <= cfg_data;
          REG_MARGIN_TOP:    margins.top    <= cfg_data[4:0];
          REG_MARGIN_BOTTOM: margins.bottom <= cfg_data[4:0];
          default: ;
        endcase
      end

      pw_en <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            quiet      <= 1'b0;
            res_scroll <= 1'b0;
            res_drop   <= 1'b0;
            res_read   <= 1'b0;
            state      <= ST_RESP;
            case (func)
              FUNC_PUT: begin
                cur_col    <= put.col;
                cur_row    <= put.row;
                res_scroll <= put.scroll;
                res_drop   <= put.drop;
                pw_en      <= put.store;
                pw_addr    <= cell_addr({1'b0, put.wr_col}, {1'b0, put.wr_row});
                pw_copy    <= 1'b0;
                pw_data    <= char_code;
                if (put.scroll) begin
                  state <= ST_SCR_WAIT;
                end
              end
              FUNC_CLEAR: begin
                cur_col <= margins.left;
                cur_row <= margins.top;
                clr_cnt <= '0;
                state   <= ST_CLEAR;
              end
              FUNC_READ: begin
                res_read <= cell_in_buf({1'b0, new_x}, {1'b0, new_y}, COLS, ROWS);
              end
              default: ;
            endcase
          end
        end

        ST_CLEAR: begin
          pw_en   <= 1'b1;
          pw_addr <= clr_cnt;
          pw_copy <= 1'b0;
          pw_data <= 8'd0;
          if (clr_cnt == AW'(NCELLS - 1)) begin
            state <= ST_RESP;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end

        // lets the put's own cell write land before the copy reads
        ST_SCR_WAIT: begin
          sx <= margins.left;
          sy <= margins.top;
          if (margins.left >= margins.right) begin
            state <= ST_RESP;
          end else if ({1'b0, margins.top} + 6'd1 < {1'b0, margins.bottom}) begin
            state <= ST_COPY;
          end else begin
            state <= ST_FILL;
          end
        end

        ST_COPY: begin
          pw_en   <= src_ok && cell_in_buf({1'b0, sx}, {1'b0, sy}, COLS, ROWS);
          pw_addr <= cell_addr({1'b0, sx}, {1'b0, sy});
          pw_copy <= 1'b1;
          if (sx_inc == margins.right) begin
            sx <= margins.left;
            if ({1'b0, sy} + 6'd2 < {1'b0, margins.bottom}) begin
              sy <= sy + 5'd1;
            end else begin
              state <= ST_FILL;
            end
          end else begin
            sx <= sx_inc;
          end
        end

        ST_FILL: begin
          pw_en   <= cell_in_buf({1'b0, sx}, {1'b0, fill_row}, COLS, ROWS);
          pw_addr <= cell_addr({1'b0, sx}, {1'b0, fill_row});
          pw_copy <= 1'b0;
          pw_data <= CH_SPACE;
          if (sx_inc == margins.right) begin
            state <= ST_RESP;
          end else begin
            sx <= sx_inc;
          end
        end

        ST_RESP: begin
          if (quiet) begin
            state <= ST_IDLE;
          end else if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            cursor_col    <= cur_col;
            cursor_row    <= cur_row;
            read_char     <= res_read ? rdata : 8'd0;
            scrolled      <= res_scroll;
            write_dropped <= res_drop;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/tcsw_checker.sv
module tcsw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] cursor_col,
  input logic [4:0] cursor_row,
  input logic [7:0] read_char,
  input logic       scrolled,
  input logic       write_dropped
);

  // reset starts the clearing pass: no input taken, no result shown
  a_reset_busy: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input not stalled or result shown after reset");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({cursor_col, cursor_row, read_char, scrolled, write_dropped}))
    else $error("stalled result changed");

  // read data only comes with a read, which never scrolls or drops
  a_read_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_char != 8'd0 |-> !scrolled && !write_dropped)
    else $error("read data together with put flags");

endmodule

bind text_cursor_scroll_writer tcsw_checker u_tcsw_checker (.*);
